[sv/bmh_pkg.sv]
// -----------------------------------------------------------------------------
// bmh_pkg: shared types and constants for the bounded min-heap
// Node layout, heap geometry, level-cell command bundle and the codes used
// between the level cells and the heap sequencer.
// -----------------------------------------------------------------------------
package bmh_pkg;

  // Heap geometry: positions are 1-based, level L holds positions 2^L .. 2^(L+1)-1.
  localparam int DEPTH = 64;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int LVLS  = PW;
  localparam int LW    = $clog2(LVLS);
  localparam int AW    = (LVLS > 2) ? LVLS - 2 : 1;

  // Field widths fixed by the stream payload.
  localparam int VAL_W      = 32;
  localparam int PAY_W      = 32;
  localparam int CAP_W      = 7;
  localparam int CNT_W      = 7;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = VAL_W + PAY_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_RAW_W  = 2 * (VAL_W + PAY_W) + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2 + STAT_W;
  localparam int CAP_RESET  = 64;

  // Operation codes carried on the input user sideband.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAY_W-1:0]        payload;
    logic signed [VAL_W-1:0] value;
  } node_t;

  // A sibling pair; lane 0 is the left child.
  typedef node_t [1:0] pair_t;

  // Outcome of the sift-down compare in a level cell.
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_LEFT,
    SEL_RIGHT
  } sel_e;

  // Where a heap position lives: level cell, pair word and lane.
  typedef struct packed {
    logic [LW-1:0] lvl;
    logic [AW-1:0] addr;
    logic          lane;
  } pos_t;

  // Command bundle broadcast from the sequencer to all level cells.
  typedef struct packed {
    logic          rd_en;
    logic [LW-1:0] rd_lvl;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rd_mask;
    logic          wr_en;
    logic [LW-1:0] wr_lvl;
    logic [AW-1:0] wr_addr;
    logic          wr_lane;
    node_t         wr_node;
  } cell_cmd_t;

  // Split a 1-based heap position into level, pair word and lane.
  function automatic pos_t pos_map(logic [PW-1:0] p);
    pos_t          r;
    logic [PW-1:0] off;
    r   = '0;
    off = '0;
    for (int b = 0; b < PW; b++) begin
      if (p[b]) begin
        r.lvl = LW'(b);
      end
    end
    off    = p & ~(PW'(1) << r.lvl);
    r.addr = AW'(off >> 1);
    r.lane = off[0];
    return r;
  endfunction

endpackage

[sv/bmh_ram.sv]
// -----------------------------------------------------------------------------
// bmh_ram: node storage of one heap level
// Sibling pairs in one word, each lane written on its own, registered read.
// -----------------------------------------------------------------------------
module bmh_ram #(
  parameter int  WORDS = 1,
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic            wlane_i,
  input  bmh_pkg::node_t  wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output bmh_pkg::pair_t  rdata_o
);
  import bmh_pkg::*;

  node_t mem_lo [WORDS];
  node_t mem_hi [WORDS];

  generate
    if (WORDS == 1) begin : g_single
      // A single pair word needs no address decode.
      always_ff @(posedge clk_i) begin
        if (we_i && !wlane_i) begin
          mem_lo[0] <= wdata_i;
        end
        if (we_i && wlane_i) begin
          mem_hi[0] <= wdata_i;
        end
        if (re_i) begin
          rdata_o <= {mem_hi[0], mem_lo[0]};
        end
      end
    end else begin : g_multi
      always_ff @(posedge clk_i) begin
        if (we_i && !wlane_i) begin
          mem_lo[waddr_i] <= wdata_i;
        end
        if (we_i && wlane_i) begin
          mem_hi[waddr_i] <= wdata_i;
        end
        if (re_i) begin
          rdata_o <= {mem_hi[raddr_i], mem_lo[raddr_i]};
        end
      end
    end
  endgenerate

endmodule

[sv/bmh_cell.sv]
// -----------------------------------------------------------------------------
// bmh_cell: one level of the heap
// Decodes the broadcast command for its level, steers its level memory and
// picks the node that moves up into the hole above during a sift-down.
// -----------------------------------------------------------------------------
module bmh_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bmh_pkg::LW-1:0] lvl_i,
  input  bmh_pkg::cell_cmd_t    cmd_i,
  input  bmh_pkg::node_t        x_i,
  input  bmh_pkg::pair_t        rdata_i,
  output logic                  re_o,
  output logic                  we_o,
  output bmh_pkg::sel_e         sel_o,
  output bmh_pkg::node_t        best_o
);
  import bmh_pkg::*;

  logic [1:0] mask_q;
  logic [1:0] mask_d;

  // Level decode of the broadcast command.
  assign re_o = cmd_i.rd_en && (cmd_i.rd_lvl == lvl_i);
  assign we_o = cmd_i.wr_en && (cmd_i.wr_lvl == lvl_i);

  // The child-valid mask travels with the read so it lines up with the data.
  assign mask_d = re_o ? cmd_i.rd_mask : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Smallest of the node in flight and the valid children; ties keep the
  // earlier candidate, the left child is tried before the right one.
  always_comb begin
    best_o = x_i;
    sel_o  = SEL_NONE;
    if (mask_q[0] && (best_o.value > rdata_i[0].value)) begin
      best_o = rdata_i[0];
      sel_o  = SEL_LEFT;
    end
    if (mask_q[1] && (best_o.value > rdata_i[1].value)) begin
      best_o = rdata_i[1];
      sel_o  = SEL_RIGHT;
    end
  end

endmodule

[sv/bounded_min_heap_topk.sv]
// -----------------------------------------------------------------------------
// bounded_min_heap_topk: top-K keeper on a bounded binary min-heap
// A row of level cells, one per heap level, each owning the nodes of its
// level, driven by one sift sequencer that moves a node between levels.
// -----------------------------------------------------------------------------
// One transaction is handled at a time. An insert into a heap that is not
// full appends the new node and lets it climb; an extract moves the last
// node into the root and lets it descend; an eviction is both in a row. A
// dropped insert or an extract from an empty heap goes straight to the
// result. Each heap level is handled by a registered read of that level's
// memory, then a compare and a write of the level above or below. The next
// input is taken as soon as the result is in the output register, even while
// that result still waits to be taken.
// Nothing needs clearing after reset: the fill count decides which nodes exist.
module bounded_min_heap_topk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream. tdata: new_value, new_payload. tuser: op.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bmh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [bmh_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // Result stream. tdata: taken_value, taken_payload, root_value,
  // root_payload, fill_count. tuser: taken_valid, root_valid, status.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [bmh_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  // Capacity register write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmh_pkg::CAP_W-1:0]       cfg_data_i
);
  import bmh_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TAKE    = 3'd1;
  localparam logic [2:0] S_LAST_WT = 3'd2;
  localparam logic [2:0] S_DN_RD   = 3'd3;
  localparam logic [2:0] S_DN_CMP  = 3'd4;
  localparam logic [2:0] S_UP_RD   = 3'd5;
  localparam logic [2:0] S_UP_CMP  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [PW-1:0]     count_q, count_d;
  logic [CAP_W-1:0]  cap_q;
  node_t             root_q, root_d;
  node_t             x_q, x_d;
  node_t             new_q, new_d;
  logic [PW-1:0]     hole_q, hole_d;
  logic [PW-1:0]     child_q, child_d;
  logic              evict_q, evict_d;
  logic              tv_q, tv_d;
  node_t             taken_q, taken_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [LW-1:0]     rd_lvl_q, rd_lvl_d;
  logic              rd_lane_q, rd_lane_d;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_USER_W-1:0] out_user_q, out_user_d;
  logic                  load_out;

  logic [PW-1:0] eff_cap;
  node_t         in_node;
  cell_cmd_t     cmd;
  logic [PW-1:0] rd_pos, wr_pos;
  pos_t          rd_map, wr_map;
  logic [PW:0]   child_w;
  logic          child_ok, right_ok;
  logic          dn_done;
  node_t         par_node;

  pair_t rd_pair   [LVLS];
  sel_e  cell_sel  [LVLS];
  node_t cell_best [LVLS];

  assign in_node.value   = s_axis_tdata[VAL_W-1:0];
  assign in_node.payload = s_axis_tdata[IN_DATA_W-1:VAL_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Capacity saturated to 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = PW'(1);
    end else if (int'(cap_q) > DEPTH) begin
      eff_cap = PW'(DEPTH);
    end else begin
      eff_cap = PW'(cap_q);
    end
  end

  // Children of the hole during a sift-down.
  assign child_w  = {hole_q, 1'b0};
  assign child_ok = child_w <= {1'b0, count_q};
  assign right_ok = (child_w + (PW + 1)'(1)) <= {1'b0, count_q};
  assign par_node = rd_pair[rd_lvl_q][rd_lane_q];

  // Sift sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    root_d    = root_q;
    x_d       = x_q;
    new_d     = new_q;
    hole_d    = hole_q;
    child_d   = child_q;
    evict_d   = evict_q;
    tv_d      = tv_q;
    taken_d   = taken_q;
    status_d  = status_q;
    rd_lvl_d  = rd_lvl_q;
    rd_lane_d = rd_lane_q;
    cmd       = '0;
    rd_pos    = '0;
    wr_pos    = '0;
    dn_done   = 1'b0;
    load_out  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          taken_d  = '0;
          tv_d     = 1'b0;
          evict_d  = 1'b0;
          status_d = ST_DONE;
          if (s_axis_tuser[0] == OP_INSERT) begin
            if (count_q < eff_cap) begin
              x_d     = in_node;
              hole_d  = count_q + PW'(1);
              count_d = count_q + PW'(1);
              state_d = S_UP_RD;
            end else if (in_node.value > root_q.value) begin
              taken_d = root_q;
              tv_d    = 1'b1;
              evict_d = 1'b1;
              new_d   = in_node;
              state_d = S_TAKE;
            end else begin
              status_d = ST_DROP;
              state_d  = S_FIN;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              taken_d = root_q;
              tv_d    = 1'b1;
              state_d = S_TAKE;
            end
          end
        end
      end
      S_TAKE: begin
        // Remove the root: a lone root just goes, otherwise fetch the last node.
        if (count_q == PW'(1)) begin
          count_d = '0;
          dn_done = 1'b1;
        end else begin
          rd_pos     = count_q;
          cmd.rd_en  = 1'b1;
          state_d    = S_LAST_WT;
        end
      end
      S_LAST_WT: begin
        x_d     = par_node;
        count_d = count_q - PW'(1);
        hole_d  = PW'(1);
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        if (child_ok) begin
          rd_pos      = child_w[PW-1:0];
          cmd.rd_en   = 1'b1;
          cmd.rd_mask = {right_ok, 1'b1};
          child_d     = child_w[PW-1:0];
          state_d     = S_DN_CMP;
        end else begin
          wr_pos       = hole_q;
          cmd.wr_en    = 1'b1;
          cmd.wr_node  = x_q;
          dn_done      = 1'b1;
        end
      end
      S_DN_CMP: begin
        wr_pos    = hole_q;
        cmd.wr_en = 1'b1;
        if (cell_sel[rd_lvl_q] == SEL_NONE) begin
          cmd.wr_node = x_q;
          dn_done     = 1'b1;
        end else begin
          cmd.wr_node = cell_best[rd_lvl_q];
          hole_d      = child_q | PW'(cell_sel[rd_lvl_q] == SEL_RIGHT);
          state_d     = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (hole_q == PW'(1)) begin
          wr_pos      = hole_q;
          cmd.wr_en   = 1'b1;
          cmd.wr_node = x_q;
          state_d     = S_FIN;
        end else begin
          rd_pos    = hole_q >> 1;
          cmd.rd_en = 1'b1;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_pos    = hole_q;
        cmd.wr_en = 1'b1;
        if (par_node.value > x_q.value) begin
          cmd.wr_node = par_node;
          hole_d      = hole_q >> 1;
          state_d     = S_UP_RD;
        end else begin
          cmd.wr_node = x_q;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase

    // After the sift-down an eviction goes on to append the new node.
    if (dn_done) begin
      if (evict_q) begin
        x_d     = new_q;
        hole_d  = count_d + PW'(1);
        count_d = count_d + PW'(1);
        state_d = S_UP_RD;
      end else begin
        state_d = S_FIN;
      end
    end

    // Position to level, word and lane for the broadcast command.
    rd_map      = pos_map(rd_pos);
    wr_map      = pos_map(wr_pos);
    cmd.rd_lvl  = rd_map.lvl;
    cmd.rd_addr = rd_map.addr;
    cmd.wr_lvl  = wr_map.lvl;
    cmd.wr_addr = wr_map.addr;
    cmd.wr_lane = wr_map.lane;
    if (cmd.rd_en) begin
      rd_lvl_d  = rd_map.lvl;
      rd_lane_d = rd_map.lane;
    end

    // The root is mirrored in a register for the output and the evict check.
    if (cmd.wr_en && (wr_pos == PW'(1))) begin
      root_d = cmd.wr_node;
    end
  end

  // Result packing.
  always_comb begin
    node_t root_out;
    root_out = (count_q != '0) ? root_q : '0;
    out_data_d = OUT_DATA_W'({CNT_W'(count_q), root_out.payload, root_out.value,
                              taken_q.payload, taken_q.value});
    out_user_d = {status_q, (count_q != '0), tv_q};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_W'(CAP_RESET);
      evict_q     <= 1'b0;
      tv_q        <= 1'b0;
      status_q    <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      evict_q  <= evict_d;
      tv_q     <= tv_d;
      status_q <= status_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    root_q    <= root_d;
    x_q       <= x_d;
    new_q     <= new_d;
    hole_q    <= hole_d;
    child_q   <= child_d;
    taken_q   <= taken_d;
    rd_lvl_q  <= rd_lvl_d;
    rd_lane_q <= rd_lane_d;
    if (load_out) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  // One cell and one level memory per heap level, sized to the positions used.
  for (genvar L = 0; L < LVLS; L++) begin : g_lvl
    localparam int FIRST = 1 << L;
    localparam int NODES = (FIRST < DEPTH + 1 - FIRST) ? FIRST : DEPTH + 1 - FIRST;
    localparam int WORDS = (NODES + 1) / 2;
    localparam int RAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic re;
    logic we;

    bmh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .lvl_i   (LW'(L)),
      .cmd_i   (cmd),
      .x_i     (x_q),
      .rdata_i (rd_pair[L]),
      .re_o    (re),
      .we_o    (we),
      .sel_o   (cell_sel[L]),
      .best_o  (cell_best[L])
    );

    bmh_ram #(
      .WORDS(WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (cmd.wr_addr[RAW-1:0]),
      .wlane_i (cmd.wr_lane),
      .wdata_i (cmd.wr_node),
      .re_i    (re),
      .raddr_i (cmd.rd_addr[RAW-1:0]),
      .rdata_o (rd_pair[L])
    );
  end

endmodule

[sv/bmh_checker.sv]
// -----------------------------------------------------------------------------
// bmh_checker: port-level checks for the bounded min-heap
// Watches the stream ports and flags results that the heap cannot produce.
// -----------------------------------------------------------------------------
module bmh_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bmh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [bmh_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import bmh_pkg::*;

  logic [CNT_W-1:0]  fill;
  logic [STAT_W-1:0] status;

  assign fill   = m_axis_tdata[2*(VAL_W+PAY_W) +: CNT_W];
  assign status = m_axis_tuser[2 +: STAT_W];

  // One transaction at a time: the input side closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in progress");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The fill never exceeds the heap depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(fill) <= DEPTH)
    else $error("fill count above heap depth");

  // The root is reported exactly when the heap holds nodes.
  a_root_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1] == (fill != '0)))
    else $error("root flag disagrees with fill count");

  // Dropped inserts and empty extracts never report a taken node; an empty extract shows a fill of zero.
  a_no_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_DROP || status == ST_EMPTY) |->
      !m_axis_tuser[0] && (status != ST_EMPTY || fill == '0))
    else $error("taken node reported on a drop or empty extract");

endmodule

bind bounded_min_heap_topk bmh_checker u_bmh_checker (.*);

[bench/tb_bounded_min_heap_topk.sv]
// -----------------------------------------------------------------------------
// tb_bounded_min_heap_topk: self-checking bench for the top-K min-heap keeper
// A short table of directed operations runs first, then phases of random
// inserts and extracts under changing capacities and back-pressure. A
// behavioral heap model predicts each result the table leaves untyped, and each
// result from the output stream is compared field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module tb_bounded_min_heap_topk;
  timeunit 1ns;
  timeprecision 1ps;

  import bmh_pkg::*;

  localparam int RAND_PHASES    = 9;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 40;

  // Capacity and insert share for each random phase. The sequence drops the
  // capacity below a well-filled heap and visits values outside 1..DEPTH.
  localparam logic [CAP_W-1:0] CAP_PLAN [RAND_PHASES] =
    '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd65, 7'd2, 7'd64, 7'd33};
  localparam int INSERT_PCT [RAND_PHASES] = '{80, 60, 50, 80, 50, 60, 40, 85, 30};

  typedef struct packed {
    logic                    taken_v;
    logic signed [VAL_W-1:0] taken_value;
    logic [PAY_W-1:0]        taken_payload;
    logic                    root_v;
    logic signed [VAL_W-1:0] root_value;
    logic [PAY_W-1:0]        root_payload;
    logic [CNT_W-1:0]        fill;
    logic [STAT_W-1:0]       status;
  } heap_result_t;

  typedef struct {
    logic         op;
    logic [31:0]  value;
    logic [31:0]  payload;
    bit           typed;
    heap_result_t want;
  } heap_cmd_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i = '0;

  // Behavioral heap state: 0-based array heap, fill and capacity register.
  node_t            heap_mem [DEPTH];
  int               heap_fill = 0;
  logic [CAP_W-1:0] cap_reg = CAP_W'(CAP_RESET);

  heap_result_t     due_results_q [$];
  heap_cmd_row_t    directed_tab [$];
  int               mismatches = 0;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  bounded_min_heap_topk dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Remove the root, move the last node up and let it sink past smaller
  // children, left child first on a tie between them.
  function automatic node_t heap_pop();
    node_t top;
    node_t tmp;
    int    k;
    int    best;
    top         = heap_mem[0];
    heap_mem[0] = heap_mem[heap_fill - 1];
    heap_fill   = heap_fill - 1;
    best        = 0;
    do begin
      k = best;
      if (2 * k + 1 < heap_fill &&
          $signed(heap_mem[best].value) > $signed(heap_mem[2 * k + 1].value)) begin
        best = 2 * k + 1;
      end
      if (2 * k + 2 < heap_fill &&
          $signed(heap_mem[best].value) > $signed(heap_mem[2 * k + 2].value)) begin
        best = 2 * k + 2;
      end
      if (best != k) begin
        tmp            = heap_mem[best];
        heap_mem[best] = heap_mem[k];
        heap_mem[k]    = tmp;
      end
    end while (best != k);
    return top;
  endfunction

  // Append a node and let it climb past strictly larger parents.
  function automatic void heap_push(node_t n);
    node_t tmp;
    int    k;
    int    p;
    k             = heap_fill;
    heap_mem[k]   = n;
    heap_fill     = heap_fill + 1;
    while (k != 0) begin
      p = (k - 1) / 2;
      if (!($signed(heap_mem[p].value) > $signed(heap_mem[k].value))) begin
        break;
      end
      tmp         = heap_mem[p];
      heap_mem[p] = heap_mem[k];
      heap_mem[k] = tmp;
      k           = p;
    end
  endfunction

  // Apply one operation to the heap model and return the result it yields.
  function automatic heap_result_t heap_apply(logic op, logic [31:0] value,
                                              logic [31:0] payload);
    heap_result_t res;
    node_t        n;
    node_t        taken;
    int           eff_cap;
    res           = '0;
    n.value       = value;
    n.payload     = payload;
    eff_cap       = (cap_reg < 1) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    if (op == OP_INSERT) begin
      if (heap_fill < eff_cap) begin
        heap_push(n);
        res.status = ST_DONE;
      end else if ($signed(n.value) > $signed(heap_mem[0].value)) begin
        taken             = heap_pop();
        res.taken_v       = 1'b1;
        res.taken_value   = taken.value;
        res.taken_payload = taken.payload;
        heap_push(n);
        res.status = ST_DONE;
      end else begin
        res.status = ST_DROP;
      end
    end else if (heap_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      taken             = heap_pop();
      res.taken_v       = 1'b1;
      res.taken_value   = taken.value;
      res.taken_payload = taken.payload;
      res.status        = ST_DONE;
    end
    if (heap_fill != 0) begin
      res.root_v       = 1'b1;
      res.root_value   = heap_mem[0].value;
      res.root_payload = heap_mem[0].payload;
    end
    res.fill = CNT_W'(heap_fill);
    return res;
  endfunction

  function automatic heap_result_t mk_result(logic tv, logic [31:0] tval,
                                             logic [31:0] tpay, logic rv,
                                             logic [31:0] rval, logic [31:0] rpay,
                                             int fill, logic [STAT_W-1:0] st);
    heap_result_t r;
    r.taken_v       = tv;
    r.taken_value   = tval;
    r.taken_payload = tpay;
    r.root_v        = rv;
    r.root_value    = rval;
    r.root_payload  = rpay;
    r.fill          = CNT_W'(fill);
    r.status        = st;
    return r;
  endfunction

  function automatic heap_cmd_row_t mk_row(logic op, logic [31:0] value,
                                           logic [31:0] payload, bit typed,
                                           heap_result_t want);
    heap_cmd_row_t row;
    row.op      = op;
    row.value   = value;
    row.payload = payload;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
      mismatches++;
    end
  endfunction

  // Send one input transaction after a random gap; the model is updated when
  // the block takes it. Starts and ends at a falling edge.
  task automatic send_heap_op(logic op, logic [31:0] value, logic [31:0] payload,
                              bit typed, heap_result_t want);
    heap_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {payload, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    got = heap_apply(op, value, payload);
    due_results_q.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  // Write the capacity register once every pending result has come back.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    s_axis_tvalid <= 1'b0;
    while (due_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random operation with values biased toward ties and the extremes.
  task automatic send_random_op(int insert_pct);
    logic [31:0] value;
    logic        op;
    case ($urandom_range(9))
      4, 5, 6: value = 32'($signed($urandom_range(8)) - 4);
      7:       value = 32'h7FFF_FFFF;
      8:       value = 32'h8000_0000;
      default: value = $urandom;
    endcase
    op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
    send_heap_op(op, value, $urandom, 1'b0, '0);
  endtask

  // Output ready toggles at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result with no prediction pending", $realtime);
        end
        mismatches++;
      end else begin
        want = due_results_q.pop_front();
        cmp_field("taken_valid", 32'(want.taken_v), 32'(m_axis_tuser[0]));
        cmp_field("taken_value", want.taken_value, m_axis_tdata[31:0]);
        cmp_field("taken_payload", want.taken_payload, m_axis_tdata[63:32]);
        cmp_field("root_valid", 32'(want.root_v), 32'(m_axis_tuser[1]));
        cmp_field("root_value", want.root_value, m_axis_tdata[95:64]);
        cmp_field("root_payload", want.root_payload, m_axis_tdata[127:96]);
        cmp_field("fill_count", 32'(want.fill), 32'(m_axis_tdata[134:128]));
        cmp_field("status", 32'(want.status), 32'(m_axis_tuser[3:2]));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    heap_result_t none;
    none = '0;

    // Directed table, run with a capacity of three. Rows with a typed result
    // cover the empty heap, the extreme values and a drop on an equal value.
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h0, 32'h0, 1'b1,
      mk_result(1'b0, 0, 0, 1'b0, 0, 0, 0, ST_EMPTY)));
    directed_tab.push_back(mk_row(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      mk_result(1'b0, 0, 0, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE)));
    directed_tab.push_back(mk_row(OP_INSERT, 32'h8000_0000, 32'h0, 1'b1,
      mk_result(1'b0, 0, 0, 1'b1, 32'h8000_0000, 32'h0, 2, ST_DONE)));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd5, 32'hA5A5_A5A5, 1'b1,
      mk_result(1'b0, 0, 0, 1'b1, 32'h8000_0000, 32'h0, 3, ST_DONE)));
    directed_tab.push_back(mk_row(OP_INSERT, 32'h8000_0000, 32'h1, 1'b1,
      mk_result(1'b0, 0, 0, 1'b1, 32'h8000_0000, 32'h0, 3, ST_DROP)));
    // Eviction, then drops on an equal and on a smaller value.
    directed_tab.push_back(mk_row(OP_INSERT, 32'd7, 32'h2, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd5, 32'h3, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd4, 32'h4, 1'b0, none));
    // Drain; the data inputs carry junk that an extract must ignore.
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h5A5A_5A5A, 32'hC3C3_C3C3, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h8000_0000, 32'h0, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      mk_result(1'b0, 0, 0, 1'b0, 0, 0, 0, ST_EMPTY)));
    // Equal values: tie handling in the sifts must match the model's.
    directed_tab.push_back(mk_row(OP_INSERT, 32'd10, 32'h1, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd10, 32'h2, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd10, 32'h3, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd10, 32'h4, 1'b0, none));
    directed_tab.push_back(mk_row(OP_INSERT, 32'd11, 32'h5, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h0, 32'h0, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h0, 32'h0, 1'b0, none));
    directed_tab.push_back(mk_row(OP_EXTRACT, 32'h0, 32'h0, 1'b0, none));

    // Reset held, then released at a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_capacity(CAP_W'(3));
    foreach (directed_tab[i]) begin
      send_heap_op(directed_tab[i].op, directed_tab[i].value, directed_tab[i].payload,
                   directed_tab[i].typed, directed_tab[i].want);
    end

    // Random phases: the receiver idles more, then the sender does, then neither.
    for (int p = 0; p < RAND_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 17 : ((p < 6) ? 74 : 0);
      recv_idle_pct = (p < 3) ? 74 : ((p < 6) ? 17 : 0);
      write_capacity(CAP_PLAN[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_op(INSERT_PCT[p]);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results drain, then settle.
    while (due_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[bounded_min_heap_topk.f]
sv/bmh_pkg.sv
sv/bmh_ram.sv
sv/bmh_cell.sv
sv/bounded_min_heap_topk.sv
sv/bmh_checker.sv
bench/tb_bounded_min_heap_topk.sv
